[hdl/lws_pkg.sv]
package lws_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int ACC_W    = 40;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;

   localparam logic [2:0] REG_INVERSE  = 3'd0;
   localparam logic [2:0] REG_P_TAPS   = 3'd1;
   localparam logic [2:0] REG_P_LAG    = 3'd2;
   localparam logic [2:0] REG_U_TAPS   = 3'd3;
   localparam logic [2:0] REG_U_LAG    = 3'd4;
   localparam logic [2:0] REG_P_COEFFS = 3'd5;
   localparam logic [2:0] REG_U_COEFFS = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] first_sample;
      logic signed [SAMPLE_W-1:0] second_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] first_out;
      logic signed [SAMPLE_W-1:0] second_out;
      logic                       saturated;
   } rsp_payload_type;

   // saturate a wide value to 16 bits, clip flag in msb
   function automatic logic [SAMPLE_W:0] sat16(input logic signed [ACC_W-1:0] v);
      logic [SAMPLE_W:0] r;
      if (v > ACC_W'(signed'(32767)))
         r = {1'b1, 16'sh7fff};
      else if (v < -ACC_W'(signed'(32768)))
         r = {1'b1, 16'sh8000};
      else
         r = {1'b0, v[SAMPLE_W-1:0]};
      return r;
   endfunction

endpackage

[hdl/lws_stream_if.sv]
interface lws_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hdl/lifting_wavelet_step_top.sv]
// a pair goes through write, stage one, stage two and out states before its result is valid
// pairs are taken one at a time, only in idle; the taps are serialised by the single shared mac
//   and the one read port of each line memory
// reset: synchronous, active high; clears the configuration and sequencer registers to
//   their defaults, then clears every line memory entry before taking the first pair
module lifting_wavelet_step_top #(
   parameter int MAX_TAPS   = 4,
   parameter int LINE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   lws_stream_if.sink                 req,
   lws_stream_if.source               rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lws_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [lws_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [lws_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import lws_pkg::*;

   localparam int PW = $clog2(LINE_DEPTH);
   localparam int TW = $clog2(MAX_TAPS + 1);

   // configuration registers
   logic        inv_ff;
   logic [2:0]  ptaps_ff, plag_ff, utaps_ff, ulag_ff;
   logic [63:0] pco_ff, uco_ff;

   assign csr_pready = 1'b1;
   wire csr_wr = csr_psel & csr_penable & csr_pwrite;
   wire [2:0] csr_idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0; ptaps_ff <= 3'd1; plag_ff <= 3'd1;
         utaps_ff <= 3'd1; ulag_ff <= 3'd0; pco_ff <= '0; uco_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_INVERSE:  inv_ff   <= csr_pwdata[0];
            REG_P_TAPS:   ptaps_ff <= csr_pwdata[2:0];
            REG_P_LAG:    plag_ff  <= csr_pwdata[2:0];
            REG_U_TAPS:   utaps_ff <= csr_pwdata[2:0];
            REG_U_LAG:    ulag_ff  <= csr_pwdata[2:0];
            REG_P_COEFFS: pco_ff   <= csr_pwdata;
            REG_U_COEFFS: uco_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         REG_INVERSE:  csr_prdata = {63'd0, inv_ff};
         REG_P_TAPS:   csr_prdata = {61'd0, ptaps_ff};
         REG_P_LAG:    csr_prdata = {61'd0, plag_ff};
         REG_U_TAPS:   csr_prdata = {61'd0, utaps_ff};
         REG_U_LAG:    csr_prdata = {61'd0, ulag_ff};
         REG_P_COEFFS: csr_prdata = pco_ff;
         REG_U_COEFFS: csr_prdata = uco_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // clamped settings
   logic [TW-1:0] pt, ut;
   logic [2:0]    pd, ud;
   logic [PW:0]   a_back, e_back, l_back;
   always_comb begin
      pt = (ptaps_ff == 3'd0) ? TW'(1) :
           (32'(ptaps_ff) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(ptaps_ff);
      ut = (utaps_ff == 3'd0) ? TW'(1) :
           (32'(utaps_ff) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(utaps_ff);
      pd = (plag_ff == 3'd0) ? 3'd1 : (plag_ff > 3'd4) ? 3'd4 : plag_ff;
      ud = (ulag_ff > 3'd4) ? 3'd4 : ulag_ff;
      a_back = (PW+1)'({pd, 1'b0} - 4'd2);
      e_back = (ud == 3'd0) ? '0 : (PW+1)'({ud, 1'b0} - 4'd1);
      l_back = a_back + e_back;
   end

   // line memories: raw first phase, raw second phase, stage one with clip bit
   logic [15:0] mem_a [LINE_DEPTH];
   logic [15:0] mem_b [LINE_DEPTH];
   logic [16:0] mem_s [LINE_DEPTH];
   logic [15:0] rd_a_ff, rd_b_ff;
   logic [16:0] rd_s_ff;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_ST1_CTR, S_ST1_MAC, S_ST1_WB,
      S_ST2_CTR, S_ST2_MAC, S_ST2_DONE, S_OUT
   } state_type;

   state_type     state_ff;
   logic [PW-1:0] wp_ff, clr_ff;
   logic [TW-1:0] j_ff;
   logic          rd_pend_ff;     // a tap read is in flight
   logic [TW-1:0] jr_ff;          // tap index of the read in flight
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [15:0] ctr_ff;    // center sample of the stage
   logic [16:0]   pass_ff;        // passed-through stage sample with clip
   logic [15:0]   in_a_ff, in_b_ff;
   rsp_payload_type out_ff;
   logic          rsp_valid_ff;

   // address and memory select per state
   logic [PW-1:0] ra_a, ra_b, ra_s;
   logic          we_a, we_s;
   logic [PW-1:0] wa_s;
   logic [16:0]   wd_s;
   logic signed [15:0] cf;
   logic signed [15:0] tap_x;
   logic signed [ACC_W-1:0] rnd, v;
   logic [16:0] sv;

   function automatic logic [PW-1:0] slot(input logic [PW-1:0] wp, input logic [PW+3:0] back);
      return wp - back[PW-1:0];
   endfunction

   function automatic logic signed [15:0] coef(input logic [63:0] pk, input logic [TW-1:0] j);
      logic signed [15:0] c;
      c = '0;
      if (32'(j) < 4) c = pk[16*j[1:0] +: 16];
      return c;
   endfunction

   // tap look-back offsets (may go negative before mod: wrap by truncation)
   logic [PW+3:0] back_p1, back_u1, back_u2, back_p2;
   always_comb begin
      back_p1 = (PW+4)'(pt) - (PW+4)'(1) - (PW+4)'(j_ff);
      back_u1 = (PW+4)'(l_back) + (PW+4)'(ut) - (PW+4)'({ud, 1'b0}) - (PW+4)'(j_ff);
      back_u2 = (PW+4)'(e_back) + (PW+4)'(ut) - (PW+4)'({ud, 1'b0}) - (PW+4)'(j_ff);
      back_p2 = (PW+4)'(e_back) + (PW+4)'(pt) - (PW+4)'(1) - (PW+4)'(j_ff);
   end

   always_comb begin
      ra_a = slot(wp_ff, (PW+4)'(l_back));
      ra_b = slot(wp_ff, (PW+4)'(l_back));
      ra_s = slot(wp_ff, (PW+4)'(l_back));
      case (state_ff)
         S_ST1_CTR: begin
            ra_a = slot(wp_ff, (PW+4)'(a_back));
            ra_b = slot(wp_ff, (PW+4)'(e_back));
         end
         S_ST1_MAC: begin
            ra_b = slot(wp_ff, back_p1);
            ra_a = slot(wp_ff, back_u2);
         end
         S_ST2_CTR: begin
            ra_a = slot(wp_ff, (PW+4)'(l_back));
            ra_b = slot(wp_ff, (PW+4)'(l_back));
            ra_s = slot(wp_ff, (PW+4)'(l_back));
         end
         S_ST2_MAC: ra_s = inv_ff ? slot(wp_ff, back_p2) : slot(wp_ff, back_u1);
         default: ;
      endcase
   end

   // stage one: forward predicts a from b, inverse de-updates b from a
   // stage two: forward updates b from a', inverse de-predicts a from b
   always_comb begin
      cf = '0;
      tap_x = '0;
      case (state_ff)
         S_ST1_MAC, S_ST1_WB: begin
            cf    = inv_ff ? coef(uco_ff, jr_ff) : coef(pco_ff, jr_ff);
            tap_x = inv_ff ? signed'(rd_a_ff) : signed'(rd_b_ff);
         end
         S_ST2_MAC, S_ST2_DONE: begin
            cf    = inv_ff ? coef(pco_ff, jr_ff) : coef(uco_ff, jr_ff);
            tap_x = signed'(rd_s_ff[15:0]);
         end
         default: ;
      endcase
      rnd = (acc_ff + ACC_W'(signed'(8192))) >>> 14;
      v = '0;
      if (state_ff == S_ST2_CTR)
         v = inv_ff ? ACC_W'(ctr_ff) - rnd : ACC_W'(ctr_ff) - rnd;
      else
         v = inv_ff ? ACC_W'(ctr_ff) + rnd : ACC_W'(ctr_ff) + rnd;
      sv = sat16(v);
      we_a = (state_ff == S_WRITE);
      we_s = (state_ff == S_ST2_CTR) || (state_ff == S_CLEAR);
      wa_s = (state_ff == S_CLEAR) ? clr_ff :
             slot(wp_ff, (PW+4)'(inv_ff ? e_back : a_back));
      wd_s = (state_ff == S_CLEAR) ? '0 : sv;
   end

   wire signed [31:0] prod = cf * tap_x;

   always_ff @(posedge clock) begin
      if (we_a || state_ff == S_CLEAR) begin
         mem_a[state_ff == S_CLEAR ? clr_ff : wp_ff] <=
            (state_ff == S_CLEAR) ? '0 : in_a_ff;
         mem_b[state_ff == S_CLEAR ? clr_ff : wp_ff] <=
            (state_ff == S_CLEAR) ? '0 : in_b_ff;
      end
      if (we_s) mem_s[wa_s] <= wd_s;
      rd_a_ff <= mem_a[ra_a];
      rd_b_ff <= mem_b[ra_b];
      // stage one entry written this cycle is forwarded to a read of the same slot
      rd_s_ff <= (we_s && wa_s == ra_s) ? wd_s : mem_s[ra_s];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

   // sequencer: every tap reads one entry and the mac takes it the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wp_ff        <= '0;
         clr_ff       <= '0;
         j_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == LINE_DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) begin
               in_a_ff  <= req.payload.first_sample;
               in_b_ff  <= req.payload.second_sample;
               wp_ff    <= wp_ff + 1'b1;
               state_ff <= S_WRITE;
            end
            S_WRITE: state_ff <= S_ST1_CTR;
            S_ST1_CTR: begin
               j_ff <= '0; rd_pend_ff <= 1'b0; acc_ff <= '0;
               state_ff <= S_ST1_MAC;
            end
            S_ST1_MAC: begin
               // first cycle here delivers the center read
               if (!rd_pend_ff) ctr_ff <= inv_ff ? signed'(rd_b_ff) : signed'(rd_a_ff);
               else acc_ff <= acc_ff + ACC_W'(prod);
               rd_pend_ff <= 1'b1;
               jr_ff <= j_ff;
               j_ff <= j_ff + 1'b1;
               if (j_ff == (inv_ff ? ut : pt) - 1'b1) state_ff <= S_ST1_WB;
            end
            S_ST1_WB: begin
               acc_ff <= acc_ff + ACC_W'(prod);
               state_ff <= S_ST2_CTR;
            end
            S_ST2_CTR: begin
               // stage one sum is complete in acc: written back this cycle
               acc_ff <= '0; j_ff <= '0; rd_pend_ff <= 1'b0;
               state_ff <= S_ST2_MAC;
            end
            S_ST2_MAC: begin
               if (!rd_pend_ff) begin
                  ctr_ff  <= inv_ff ? signed'(rd_a_ff) : signed'(rd_b_ff);
                  pass_ff <= rd_s_ff;
               end else acc_ff <= acc_ff + ACC_W'(prod);
               rd_pend_ff <= 1'b1;
               jr_ff <= j_ff;
               j_ff <= j_ff + 1'b1;
               if (j_ff == (inv_ff ? pt : ut) - 1'b1) state_ff <= S_ST2_DONE;
            end
            S_ST2_DONE: begin
               acc_ff <= acc_ff + ACC_W'(prod);
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_valid_ff) begin
               if (inv_ff) begin
                  out_ff.first_out  <= sv[15:0];
                  out_ff.second_out <= pass_ff[15:0];
               end else begin
                  out_ff.first_out  <= pass_ff[15:0];
                  out_ff.second_out <= sv[15:0];
               end
               out_ff.saturated <= sv[16] | pass_ff[16];
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[verif/lifting_wavelet_step_top_tb.sv]
`timescale 1ns / 1ps
module lifting_wavelet_step_top_tb;
   import lws_pkg::*;

   localparam int DEPTH = 16;
   localparam int SETTLE_CYCLES = 40;      // longer than the longest latency of the block
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 105;
   localparam int NUM_PHASES = 8;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   typedef struct {
      logic signed [15:0] first_sample;
      logic signed [15:0] second_sample;
      bit                 typed;        // expected pair typed in below
      logic signed [15:0] first_out;
      logic signed [15:0] second_out;
      logic               saturated;
   } pair_row_t;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   lws_stream_if #(.payload_type(req_payload_type)) req_if ();
   lws_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   lifting_wavelet_step_top dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // model copy of the register file
   logic       cfg_inverse;
   logic [2:0] cfg_p_taps, cfg_p_lag, cfg_u_taps, cfg_u_lag;
   logic [63:0] cfg_p_coeffs, cfg_u_coeffs;

   // model copy of the delay lines
   logic signed [15:0] first_line [DEPTH];
   logic signed [15:0] second_line [DEPTH];
   logic signed [15:0] lifted_line [DEPTH];
   bit                 lifted_clip [DEPTH];
   int                 newest_slot;

   rsp_payload_type pending_pairs[$];
   int   mismatch_count;
   bit   failed;
   int   cycle_count;
   idle_mode_e idle_mode;
   int   holdoff_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[lifting_wavelet_step_top] ERROR");
         $finish;
      end
   end

   function automatic int line_slot(int back);
      return (newest_slot + DEPTH - (back % DEPTH)) % DEPTH;
   endfunction

   function automatic int clamp_field(logic [2:0] v, int lo, int hi);
      if (int'(v) < lo) return lo;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // src: 0 second-phase line, 1 lifted line, 2 first-phase line
   function automatic longint fir_q15(logic [63:0] packed_taps, int taps, int src, int back0);
      longint acc;
      logic signed [15:0] tap_coeff;
      logic signed [15:0] smp;
      acc = 0;
      for (int j = 0; j < taps; j++) begin
         tap_coeff = packed_taps[16*j +: 16];
         case (src)
            0: smp = second_line[line_slot(back0 - j)];
            1: smp = lifted_line[line_slot(back0 - j)];
            default: smp = first_line[line_slot(back0 - j)];
         endcase
         acc += longint'(tap_coeff) * longint'(smp);
      end
      // q29 to q15, round half up
      return (acc + 8192) >>> 14;
   endfunction

   // clip flag in bit 16
   function automatic logic [16:0] clip_q15(longint v);
      if (v > 32767) return {1'b1, 16'h7fff};
      if (v < -32768) return {1'b1, 16'h8000};
      return {1'b0, v[15:0]};
   endfunction

   // advance the line state by one pair and return the delayed lifted pair
   function automatic rsp_payload_type lift_pair(logic signed [15:0] a_in,
                                                 logic signed [15:0] b_in);
      int pt, pd, ut, ud, a_back, e_back, l_back, s;
      logic [16:0] r0, r1, rs;
      rsp_payload_type res;
      pt = clamp_field(cfg_p_taps, 1, 4);
      pd = clamp_field(cfg_p_lag, 1, 4);
      ut = clamp_field(cfg_u_taps, 1, 4);
      ud = clamp_field(cfg_u_lag, 0, 4);
      a_back = 2*pd - 2;
      e_back = (ud > 0) ? 2*ud - 1 : 0;
      l_back = a_back + e_back;
      newest_slot = (newest_slot + 1) % DEPTH;
      first_line[newest_slot] = a_in;
      second_line[newest_slot] = b_in;
      if (!cfg_inverse) begin
         // predict, then update over the predicted first phase
         s = line_slot(a_back);
         rs = clip_q15(longint'(first_line[s]) - fir_q15(cfg_p_coeffs, pt, 0, pt - 1));
         lifted_line[s] = rs[15:0];
         lifted_clip[s] = rs[16];
         r0 = {lifted_clip[line_slot(l_back)], lifted_line[line_slot(l_back)]};
         r1 = clip_q15(longint'(second_line[line_slot(l_back)])
                       + fir_q15(cfg_u_coeffs, ut, 1, l_back + ut - 2*ud));
      end else begin
         // undo update, then undo predict
         s = line_slot(e_back);
         rs = clip_q15(longint'(second_line[s])
                       - fir_q15(cfg_u_coeffs, ut, 2, e_back + ut - 2*ud));
         lifted_line[s] = rs[15:0];
         lifted_clip[s] = rs[16];
         r0 = clip_q15(longint'(first_line[line_slot(l_back)])
                       + fir_q15(cfg_p_coeffs, pt, 1, e_back + pt - 1));
         r1 = {lifted_clip[line_slot(l_back)], lifted_line[line_slot(l_back)]};
      end
      res.first_out = r0[15:0];
      res.second_out = r1[15:0];
      res.saturated = r0[16] | r1[16];
      return res;
   endfunction

   // apb write, setup then access phase; also updates the model registers
   task automatic csr_write(logic [2:0] reg_index, logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {reg_index, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_index)
         REG_INVERSE:  cfg_inverse = value[0];
         REG_P_TAPS:   cfg_p_taps = value[2:0];
         REG_P_LAG:    cfg_p_lag = value[2:0];
         REG_U_TAPS:   cfg_u_taps = value[2:0];
         REG_U_LAG:    cfg_u_lag = value[2:0];
         REG_P_COEFFS: cfg_p_coeffs = value;
         REG_U_COEFFS: cfg_u_coeffs = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   // offer one pair from a falling edge and wait for its transfer
   task automatic send_pair(pair_row_t row);
      rsp_payload_type predicted;
      while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 67) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.payload.first_sample = row.first_sample;
      req_if.payload.second_sample = row.second_sample;
      do @(posedge clock); while (!req_if.ready);
      predicted = lift_pair(row.first_sample, row.second_sample);
      if (row.typed) begin
         predicted.first_out = row.first_out;
         predicted.second_out = row.second_out;
         predicted.saturated = row.saturated;
      end
      pending_pairs.push_back(predicted);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // one pair per call through send_pair; valid drops again after each transfer
   task automatic send_stream(pair_row_t row);
      send_pair(row);
   endtask

   task automatic drain_pipeline();
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(200)) - 16'd100;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] random_coeffs(bit wide);
      logic [63:0] v;
      for (int j = 0; j < 4; j++)
         v[16*j +: 16] = wide ? 16'($urandom) : 16'($urandom_range(16384)) - 16'd8192;
      return v;
   endfunction

   // result side: ready decided at the falling edge
   always @(negedge clock) begin
      if (reset)
         rsp_if.ready = 1'b0;
      else if (holdoff_cycles > 0) begin
         holdoff_cycles = holdoff_cycles - 1;
         rsp_if.ready = 1'b0;
      end else if (idle_mode == IDLE_RECEIVER)
         rsp_if.ready = ($urandom_range(99) >= 67);
      else if (idle_mode == IDLE_BOTH)
         rsp_if.ready = ($urandom_range(99) >= 7);
      else
         rsp_if.ready = 1'b1;
   end

   // compare each result transfer with the oldest expected pair
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pairs.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %p", rsp_if.payload);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_if.payload.first_out !== want.first_out ||
                rsp_if.payload.second_out !== want.second_out ||
                rsp_if.payload.saturated !== want.saturated) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %0d sat %0b, got %0d %0d sat %0b",
                           want.first_out, want.second_out, want.saturated,
                           rsp_if.payload.first_out, rsp_if.payload.second_out,
                           rsp_if.payload.saturated);
            end
         end
      end
   end

   pair_row_t directed_rows[$];
   pair_row_t row;

   initial begin
      cycle_count = 0;
      failed = 1'b0;
      mismatch_count = 0;
      idle_mode = IDLE_NONE;
      holdoff_cycles = 0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      cfg_inverse = 1'b0;
      cfg_p_taps = 3'd1;
      cfg_p_lag = 3'd1;
      cfg_u_taps = 3'd1;
      cfg_u_lag = 3'd0;
      cfg_p_coeffs = '0;
      cfg_u_coeffs = '0;
      newest_slot = 0;
      for (int i = 0; i < DEPTH; i++) begin
         first_line[i] = '0;
         second_line[i] = '0;
         lifted_line[i] = '0;
         lifted_clip[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults: one tap with zero coefficients and no lag, so each pair comes straight back
      directed_rows = '{
         '{16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, 1'b0},
         '{16'sh7fff, 16'sh7fff, 1, 16'sh7fff, 16'sh7fff, 1'b0},
         '{16'sh8000, 16'sh8000, 1, 16'sh8000, 16'sh8000, 1'b0},
         '{16'sh7fff, 16'sh8000, 1, 16'sh7fff, 16'sh8000, 1'b0},
         '{16'sh8000, 16'sh7fff, 1, 16'sh8000, 16'sh7fff, 1'b0},
         '{16'shffff, 16'sh0001, 1, 16'shffff, 16'sh0001, 1'b0},
         '{16'sh5555, 16'shaaaa, 1, 16'sh5555, 16'shaaaa, 1'b0},
         '{16'shaaaa, 16'sh5555, 1, 16'shaaaa, 16'sh5555, 1'b0},
         '{16'sh1234, 16'shedcb, 0, 16'sh0000, 16'sh0000, 1'b0},
         '{16'sh0001, 16'shffff, 0, 16'sh0000, 16'sh0000, 1'b0}
      };
      foreach (directed_rows[i]) send_stream(directed_rows[i]);
      drain_pipeline();

      // saturation: predict coefficients -2.0 and update coefficients just under +2.0 on every tap,
      // with full-scale and zero samples, checked through the model
      csr_write(REG_P_COEFFS, 64'h8000_8000_8000_8000);
      csr_write(REG_U_COEFFS, 64'h7fff_7fff_7fff_7fff);
      csr_write(REG_P_TAPS, 3'd4);
      csr_write(REG_U_TAPS, 3'd4);
      directed_rows = '{
         '{16'sh7fff, 16'sh7fff, 0, 16'sh0, 16'sh0, 1'b0},
         '{16'sh7fff, 16'sh7fff, 0, 16'sh0, 16'sh0, 1'b0},
         '{16'sh8000, 16'sh8000, 0, 16'sh0, 16'sh0, 1'b0},
         '{16'sh8000, 16'sh7fff, 0, 16'sh0, 16'sh0, 1'b0},
         '{16'sh0000, 16'sh8000, 0, 16'sh0, 16'sh0, 1'b0},
         '{16'sh7fff, 16'sh0000, 0, 16'sh0, 16'sh0, 1'b0}
      };
      foreach (directed_rows[i]) send_stream(directed_rows[i]);
      drain_pipeline();
      csr_write(REG_INVERSE, 1'b1);
      foreach (directed_rows[i]) send_stream(directed_rows[i]);
      drain_pipeline();

      // random phases, each with its own settings and idling; state carries over
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_INVERSE, 1'b0);
               csr_write(REG_P_TAPS, 3'd1);
               csr_write(REG_P_LAG, 3'd1);
               csr_write(REG_U_TAPS, 3'd1);
               csr_write(REG_U_LAG, 3'd0);
            end
            1, 2: begin
               // largest taps and lags in both directions
               csr_write(REG_INVERSE, ph == 2);
               csr_write(REG_P_TAPS, 3'd4);
               csr_write(REG_P_LAG, 3'd4);
               csr_write(REG_U_TAPS, 3'd4);
               csr_write(REG_U_LAG, 3'd4);
            end
            3: begin
               // out of range fields clamp to their bounds
               csr_write(REG_INVERSE, 1'b1);
               csr_write(REG_P_TAPS, 3'd0);
               csr_write(REG_P_LAG, 3'd7);
               csr_write(REG_U_TAPS, 3'd7);
               csr_write(REG_U_LAG, 3'd7);
            end
            4: begin
               csr_write(REG_INVERSE, 1'b0);
               csr_write(REG_P_TAPS, 3'd7);
               csr_write(REG_P_LAG, 3'd0);
               csr_write(REG_U_TAPS, 3'd0);
               csr_write(REG_U_LAG, 3'd5);
            end
            default: begin
               csr_write(REG_INVERSE, 1'($urandom));
               csr_write(REG_P_TAPS, 3'($urandom));
               csr_write(REG_P_LAG, 3'($urandom));
               csr_write(REG_U_TAPS, 3'($urandom));
               csr_write(REG_U_LAG, 3'($urandom));
            end
         endcase
         csr_write(REG_P_COEFFS, random_coeffs(ph >= 5));
         csr_write(REG_U_COEFFS, random_coeffs(ph >= 5));
         idle_mode = idle_mode_e'(ph % 4);
         // long result stall while pairs keep coming: the block backs up
         if (ph == 1) holdoff_cycles = 400;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            row.first_sample = random_sample();
            row.second_sample = random_sample();
            row.typed = 1'b0;
            row.first_out = '0;
            row.second_out = '0;
            row.saturated = 1'b0;
            send_stream(row);
         end
         drain_pipeline();
      end

      if (!failed)
         $display("[lifting_wavelet_step_top] OK");
      else
         $display("[lifting_wavelet_step_top] ERROR");
      $finish;
   end

endmodule

[files.f]
hdl/lws_pkg.sv
hdl/lws_stream_if.sv
hdl/lifting_wavelet_step_top.sv
verif/lifting_wavelet_step_top_tb.sv
